### rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Types, opcodes and status codes shared by the positional sequence engine.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int AMT_W     = 16;
    // Width used for position compares: holds any length up to 64 plus one.
    localparam int CW        = 8;

    localparam logic [2:0] OP_INS = 3'd0;
    localparam logic [2:0] OP_REM = 3'd1;
    localparam logic [2:0] OP_MOV = 3'd2;
    localparam logic [2:0] OP_REV = 3'd3;
    localparam logic [2:0] OP_ROL = 3'd4;
    localparam logic [2:0] OP_ROR = 3'd5;
    localparam logic [2:0] OP_RD  = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
        logic [5:0]         position;
        logic [4:0]         target_position;
        logic [AMT_W-1:0]   amount;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] element;
        logic               last;
        logic               empty_res;
        logic [1:0]         status;
    } t_out_item;

endpackage

### rtl/pse_mem.sv
// ----------------------------------------------------------------------------
// pse_mem
// Simple dual-port element store, one write and one registered read port.
// ----------------------------------------------------------------------------
module pse_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [31:0]       i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [31:0]       o_rdata
);
    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/pse_remu.sv
// ----------------------------------------------------------------------------
// pse_remu
// Bit-serial restoring remainder: amount modulo length, one bit per cycle.
// ----------------------------------------------------------------------------
module pse_remu #(
    parameter int LW = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [pse_pkg::AMT_W-1:0] i_dividend,
    input  logic [LW-1:0]            i_divisor,
    output logic                     o_busy,
    output logic [LW-1:0]            o_rem
);
    import pse_pkg::*;

    localparam int NW = $clog2(AMT_W);

    logic          r_busy;
    logic [NW-1:0] r_cnt;
    logic [AMT_W-1:0] r_num;
    logic [LW-1:0] r_rem;
    logic [LW-1:0] r_div;
    logic [LW:0]   sh;
    logic [LW:0]   diff;

    assign sh   = {r_rem, r_num[AMT_W-1]};
    assign diff = sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + NW'(1);
            if (r_cnt == NW'(AMT_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[AMT_W-2:0], 1'b0};
            // remainder stays below the divisor, so the top bit drops cleanly
            r_rem <= (sh >= {1'b0, r_div}) ? diff[LW-1:0] : sh[LW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;
endmodule

### rtl/positional_sequence_engine.sv
// Flow: status-only requests go straight to the response; insert/remove/move/reverse copy the
// new sequence into the other bank and then commit it; rotate first reduces amount mod length.
// Read out: each element is read from the live bank and then issued; an output stall holds it.
// Throughput: one request at a time; the next request is taken as the last response is issued.
// Reset: synchronous, active low; length clears to zero, element store is not cleared.
// ----------------------------------------------------------------------------
// positional_sequence_engine
// Ordered sequence of signed words kept in two ping-pong memory banks.
// ----------------------------------------------------------------------------
module positional_sequence_engine #(
    parameter int DEPTH = pse_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pse_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pse_pkg::t_out_item o_out_data
);
    import pse_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_REM   = 3'd1;
    localparam logic [2:0] S_CPY   = 3'd2;
    localparam logic [2:0] S_CEND  = 3'd3;
    localparam logic [2:0] S_RES   = 3'd4;
    localparam logic [2:0] S_RORD  = 3'd5;
    localparam logic [2:0] S_RODAT = 3'd6;

    logic [2:0]  r_state;
    t_in_item    r_item;
    logic [LW-1:0] r_len, r_nlen, r_i;
    logic [AW-1:0] r_k, r_pidx;
    logic        r_bank, r_pv, r_pval;
    logic [1:0]  r_status;
    logic        r_empty;
    logic        r_ovalid;
    t_out_item   r_out;

    logic        in_acc, out_free, out_load, rem_start, rem_busy;
    logic [LW-1:0] rem_q;
    logic [CW-1:0] cw_i, pos_c, tgt_c, len_c, j_c, src_c;
    logic        use_val;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0] rd0, rd1, rdata;
    logic        w_en;
    logic [31:0] w_data;
    logic        ro_last;
    logic [LW-1:0] k_inc;
    logic [2:0]    acc_state;
    logic [1:0]    acc_status;
    logic [LW-1:0] acc_nlen;
    logic          acc_empty;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_ovalid || !i_out_stall;
    assign out_load   = out_free && (r_state == S_RES || r_state == S_RODAT);
    assign rem_start  = in_acc && (r_len != '0) &&
                        (i_in_data.opcode == OP_ROL || i_in_data.opcode == OP_ROR);

    pse_remu #(.LW(LW)) u_remu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (i_in_data.amount),
        .i_divisor  (r_len),
        .o_busy     (rem_busy),
        .o_rem      (rem_q)
    );

    // request decode: next state, status and length on acceptance
    always_comb begin
        acc_state  = S_RES;
        acc_status = ST_OK;
        acc_nlen   = r_len;
        acc_empty  = 1'b0;
        case (i_in_data.opcode)
            OP_INS: begin
                if (CW'(i_in_data.position) > CW'(r_len)) begin
                    acc_status = ST_RANGE;
                end else if (r_len == LW'(DEPTH)) begin
                    acc_status = ST_FULL;
                end else begin
                    acc_nlen  = r_len + LW'(1);
                    acc_state = S_CPY;
                end
            end
            OP_REM: begin
                if (CW'(i_in_data.position) >= CW'(r_len)) begin
                    acc_status = ST_RANGE;
                end else begin
                    acc_nlen  = r_len - LW'(1);
                    acc_state = S_CPY;
                end
            end
            OP_MOV: begin
                if (CW'(i_in_data.position) >= CW'(r_len) ||
                    CW'(i_in_data.target_position) >= CW'(r_len)) begin
                    acc_status = ST_RANGE;
                end else if (CW'(i_in_data.position) !=
                             CW'(i_in_data.target_position)) begin
                    acc_state = S_CPY;
                end
            end
            OP_REV: begin
                if (r_len > LW'(1)) begin
                    acc_state = S_CPY;
                end
            end
            OP_ROL, OP_ROR: begin
                if (r_len != '0) begin
                    acc_state = S_REM;
                end
            end
            OP_RD: begin
                if (r_len == '0) begin
                    acc_empty = 1'b1;
                end else begin
                    acc_state = S_RORD;
                end
            end
            default: acc_status = ST_RANGE;
        endcase
    end

    // source index of new element i
    assign cw_i  = CW'(r_i);
    assign pos_c = CW'(r_item.position);
    assign tgt_c = CW'(r_item.target_position);
    assign len_c = CW'(r_len);
    assign j_c   = (cw_i < tgt_c) ? cw_i : cw_i - CW'(1);

    always_comb begin
        case (r_item.opcode)
            OP_INS:  src_c = (cw_i < pos_c) ? cw_i : cw_i - CW'(1);
            OP_REM:  src_c = (cw_i < pos_c) ? cw_i : cw_i + CW'(1);
            OP_MOV:  src_c = (cw_i == tgt_c) ? pos_c :
                             ((j_c < pos_c) ? j_c : j_c + CW'(1));
            OP_REV:  src_c = len_c - CW'(1) - cw_i;
            default: src_c = CW'(r_k);
        endcase
    end

    assign use_val = (r_item.opcode == OP_INS) && (cw_i == pos_c);
    assign k_inc   = LW'(r_k) + LW'(1);
    assign ro_last = ((r_i + LW'(1)) == r_len);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = AW'(r_i);
        if (r_state == S_CPY && r_i < r_nlen) begin
            rd_en   = !use_val;
            rd_addr = AW'(src_c);
        end else if (r_state == S_RORD) begin
            rd_en = 1'b1;
        end
    end

    assign rdata  = r_bank ? rd1 : rd0;
    assign w_en   = r_pv && (r_state == S_CPY || r_state == S_CEND);
    assign w_data = r_pval ? r_item.value : rdata;

    pse_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem0 (
        .i_clk   (i_clk),
        .i_we    (w_en && r_bank),
        .i_waddr (r_pidx),
        .i_wdata (w_data),
        .i_re    (rd_en && !r_bank),
        .i_raddr (rd_addr),
        .o_rdata (rd0)
    );

    pse_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem1 (
        .i_clk   (i_clk),
        .i_we    (w_en && !r_bank),
        .i_waddr (r_pidx),
        .i_wdata (w_data),
        .i_re    (rd_en && r_bank),
        .i_raddr (rd_addr),
        .o_rdata (rd1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_bank   <= 1'b0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_free) begin
                r_ovalid <= out_load;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_item   <= i_in_data;
                        r_i      <= '0;
                        r_nlen   <= acc_nlen;
                        r_status <= acc_status;
                        r_empty  <= acc_empty;
                        r_state  <= acc_state;
                    end
                end
                S_REM: begin
                    if (!rem_busy) begin
                        if (rem_q == '0) begin
                            r_state <= S_RES;
                        end else begin
                            r_k     <= (r_item.opcode == OP_ROL) ? AW'(rem_q)
                                                                 : AW'(r_len - rem_q);
                            r_state <= S_CPY;
                        end
                    end
                end
                S_CPY: begin
                    if (r_i < r_nlen) begin
                        r_pv   <= 1'b1;
                        r_pidx <= AW'(r_i);
                        r_pval <= use_val;
                        r_i    <= r_i + LW'(1);
                        r_k    <= (k_inc == r_len) ? '0 : AW'(k_inc);
                    end else begin
                        r_pv    <= 1'b0;
                        r_state <= S_CEND;
                    end
                end
                S_CEND: begin
                    // last write landed on the previous edge; new bank goes live
                    r_pv    <= 1'b0;
                    r_bank  <= !r_bank;
                    r_len   <= r_nlen;
                    r_state <= S_RES;
                end
                S_RES: begin
                    if (out_free) begin
                        r_out    <= '{element: '0, last: 1'b1,
                                      empty_res: r_empty, status: r_status};
                        r_state  <= S_IDLE;
                    end
                end
                S_RORD: begin
                    r_state <= S_RODAT;
                end
                S_RODAT: begin
                    if (out_free) begin
                        r_out    <= '{element: rdata, last: ro_last,
                                      empty_res: 1'b0, status: ST_OK};
                        r_i      <= r_i + LW'(1);
                        r_state  <= ro_last ? S_IDLE : S_RORD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(DEPTH))
        else $error("length beyond store depth");

    a_len_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(r_len) |-> $past(r_state) == S_CEND)
        else $error("length changed outside copy commit");

    a_write_shadow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |-> (r_state == S_CPY || r_state == S_CEND) && !rd_en ||
                 (r_state == S_CPY))
        else $error("write outside copy");

    a_live_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RODAT) |-> $past(r_state) == S_RORD || $past(r_state) == S_RODAT)
        else $error("read data used without a read");
`endif
endmodule

### test/positional_sequence_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_sequence_engine_test
// Drives insert, remove, move, reverse, rotate and read-out requests into the
// engine, predicts every response from a software copy of the sequence and
// checks each response field by field in order.
// ----------------------------------------------------------------------------
module positional_sequence_engine_test;
    import pse_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    positional_sequence_engine #(.DEPTH(DEPTH)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    t_in_item    pending_q[$];
    t_out_item   expected_q[$];
    logic [31:0] seq_model[DEPTH];
    int          seq_len = 0;
    int          mismatch_count = 0;
    int          burst_left;
    int          gap_left;
    bit          hold_for_drain;
    int          rx_hold;
    bit          long_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatch_count++;
    endtask

    function automatic void add_pending(input t_in_item it);
        pending_q.insert(pending_q.size(), it);
    endfunction

    function automatic void add_expected(input t_out_item r);
        expected_q.insert(expected_q.size(), r);
    endfunction

    function automatic t_out_item status_res(input logic [1:0] st);
        t_out_item r;
        r = '0;
        r.last = 1'b1;
        r.status = st;
        return r;
    endfunction

    function automatic void rotate_seq_left(input int amt);
        logic [31:0] tmp[DEPTH];
        if (seq_len == 0) return;
        amt = amt % seq_len;
        for (int i = 0; i < seq_len; i++) tmp[i] = seq_model[(i + amt) % seq_len];
        for (int i = 0; i < seq_len; i++) seq_model[i] = tmp[i];
    endfunction

    // Applies one request to the software sequence and queues its responses.
    function automatic void predict_sequence(input t_in_item it);
        int          pos;
        int          tgt;
        int          a;
        int          b;
        logic [31:0] moved;
        logic [31:0] t;
        t_out_item   r;
        pos = int'(it.position);
        tgt = int'(it.target_position);
        case (it.opcode)
            OP_INS: begin
                if (pos > seq_len) add_expected(status_res(ST_RANGE));
                else if (seq_len >= DEPTH) add_expected(status_res(ST_FULL));
                else begin
                    for (int i = seq_len; i > pos; i--) seq_model[i] = seq_model[i-1];
                    seq_model[pos] = it.value;
                    seq_len++;
                    add_expected(status_res(ST_OK));
                end
            end
            OP_REM: begin
                if (pos >= seq_len) add_expected(status_res(ST_RANGE));
                else begin
                    for (int i = pos; i + 1 < seq_len; i++) seq_model[i] = seq_model[i+1];
                    seq_len--;
                    add_expected(status_res(ST_OK));
                end
            end
            OP_MOV: begin
                if (pos >= seq_len || tgt >= seq_len) add_expected(status_res(ST_RANGE));
                else begin
                    moved = seq_model[pos];
                    for (int i = pos; i + 1 < seq_len; i++) seq_model[i] = seq_model[i+1];
                    for (int i = seq_len - 1; i > tgt; i--) seq_model[i] = seq_model[i-1];
                    seq_model[tgt] = moved;
                    add_expected(status_res(ST_OK));
                end
            end
            OP_REV: begin
                a = 0;
                b = seq_len - 1;
                while (a < b) begin
                    t = seq_model[a];
                    seq_model[a] = seq_model[b];
                    seq_model[b] = t;
                    a++;
                    b--;
                end
                add_expected(status_res(ST_OK));
            end
            OP_ROL: begin
                rotate_seq_left(int'(it.amount));
                add_expected(status_res(ST_OK));
            end
            OP_ROR: begin
                if (seq_len != 0) rotate_seq_left(seq_len - (int'(it.amount) % seq_len));
                add_expected(status_res(ST_OK));
            end
            OP_RD: begin
                if (seq_len == 0) begin
                    r = status_res(ST_OK);
                    r.empty_res = 1'b1;
                    add_expected(r);
                end else begin
                    for (int i = 0; i < seq_len; i++) begin
                        r = '0;
                        r.element = seq_model[i];
                        r.last = (i + 1 == seq_len);
                        add_expected(r);
                    end
                end
            end
            default: add_expected(status_res(ST_RANGE));
        endcase
    endfunction

    function automatic t_in_item make_req(input logic [2:0] op, input logic [31:0] v,
                                          input logic [5:0] p, input logic [4:0] tg,
                                          input logic [15:0] am);
        t_in_item it;
        it.opcode = op;
        it.value = v;
        it.position = p;
        it.target_position = tg;
        it.amount = am;
        return it;
    endfunction

    // Mostly sensible positions relative to a guessed length, with some noise.
    function automatic t_in_item rand_req(input int len_guess);
        t_in_item it;
        int       sel;
        it = make_req(3'($urandom_range(0, 7)), $urandom,
                      6'($urandom_range(0, len_guess + 1)),
                      5'($urandom_range(0, (len_guess > 0) ? len_guess - 1 : 0)),
                      16'($urandom));
        sel = $urandom_range(0, 99);
        if (sel < 40) it.opcode = OP_INS;
        else if (sel < 52) it.opcode = OP_REM;
        else if (sel < 95 && it.opcode == 3'd7) it.opcode = OP_MOV;
        if (sel >= 95) begin
            it.position = 6'($urandom);
            it.target_position = 5'($urandom);
        end
        if ($urandom_range(0, 3) == 0) it.amount = 16'($urandom_range(0, 70));
        return it;
    endfunction

    // Driver: bursts of requests with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid) begin
                predict_sequence(i_in_data);
                void'(pending_q.pop_front());
            end
            if (pending_q.size() == 0 || hold_for_drain) begin
                i_in_valid <= 1'b0;
            end else if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_q[0];
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Monitor and receiver stall pattern.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_hold     <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report("unexpected response", 64'(o_out_data), 64'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (o_out_data.element !== want.element)
                        report("element", 64'(o_out_data.element), 64'(want.element));
                    if (o_out_data.last !== want.last)
                        report("last", 64'(o_out_data.last), 64'(want.last));
                    if (o_out_data.empty_res !== want.empty_res)
                        report("empty_res", 64'(o_out_data.empty_res), 64'(want.empty_res));
                    if (o_out_data.status !== want.status)
                        report("status", 64'(o_out_data.status), 64'(want.status));
                end
            end
            if (long_hold_req && rx_hold == 0) begin
                rx_hold <= 300;
                i_out_stall <= 1'b1;
            end else if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                i_out_stall <= (rx_hold > 1);
            end else if ($time % 2000 < 700) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial begin
        #4000000;
        $display("positional_sequence_engine regression: fail");
        $finish;
    end

    initial begin
        int len_guess;
        hold_for_drain = 1'b0;
        long_hold_req = 1'b0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty cases, extremes, every opcode, full store.
        add_pending(make_req(OP_RD, 0, 0, 0, 0));
        add_pending(make_req(OP_REM, 0, 0, 0, 0));
        add_pending(make_req(OP_ROL, 0, 0, 0, 16'hFFFF));
        add_pending(make_req(OP_ROR, 0, 0, 0, 5));
        add_pending(make_req(OP_REV, 0, 0, 0, 0));
        add_pending(make_req(OP_MOV, 0, 0, 0, 0));
        add_pending(make_req(OP_INS, 32'h7FFFFFFF, 1, 0, 0));
        add_pending(make_req(OP_INS, 32'h80000000, 0, 0, 0));
        add_pending(make_req(OP_INS, 32'hFFFFFFFF, 2, 0, 0));
        add_pending(make_req(OP_INS, 0, 6'h3F, 5'h1F, 16'hFFFF));
        add_pending(make_req(OP_MOV, 0, 0, 2, 0));
        add_pending(make_req(OP_MOV, 0, 1, 1, 0));
        add_pending(make_req(OP_MOV, 0, 3, 0, 0));
        add_pending(make_req(OP_ROL, 0, 0, 0, 3));
        add_pending(make_req(OP_ROR, 0, 0, 0, 1));
        add_pending(make_req(OP_REV, 0, 0, 0, 0));
        add_pending(make_req(3'd7, 0, 0, 0, 0));
        add_pending(make_req(OP_RD, 0, 0, 0, 0));
        add_pending(make_req(OP_REM, 0, 3, 0, 0));
        add_pending(make_req(OP_REM, 0, 2, 0, 0));
        for (int i = 0; i < DEPTH + 1; i++)
            add_pending(make_req(OP_INS, $urandom, 6'($urandom_range(0, i)), 0, 0));
        add_pending(make_req(OP_INS, 0, 6'(DEPTH), 0, 0));
        add_pending(make_req(OP_INS, 0, 6'(DEPTH + 1), 0, 0));
        add_pending(make_req(OP_MOV, 0, 6'(DEPTH - 1), 0, 0));
        add_pending(make_req(OP_ROR, 0, 0, 0, 16'hFFFF));
        add_pending(make_req(OP_RD, 0, 0, 0, 0));
        for (int i = 0; i < 6; i++)
            add_pending(make_req(OP_ROL, 0, 0, 0, 0));
        wait (pending_q.size() == 0);

        // Long receiver hold while the sender keeps offering.
        long_hold_req <= 1'b1;
        @(posedge i_clk);
        long_hold_req <= 1'b0;

        len_guess = DEPTH;
        for (int i = 0; i < 156; i++) begin
            if (i == 78) begin
                wait (pending_q.size() == 0);
                hold_for_drain = 1'b1;
                wait (expected_q.size() == 0 && !i_in_valid);
                repeat (40) @(posedge i_clk);
                hold_for_drain = 1'b0;
            end
            if (i % 40 == 39) len_guess = $urandom_range(0, DEPTH);
            add_pending(rand_req(len_guess));
            if (pending_q.size() > 8) wait (pending_q.size() <= 4);
        end
        wait (pending_q.size() == 0 && !i_in_valid);
        wait (expected_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("positional_sequence_engine regression: pass");
        end else begin
            $display("positional_sequence_engine regression: fail");
        end
        $finish;
    end

endmodule

### files.f
rtl/pse_pkg.sv
rtl/pse_mem.sv
rtl/pse_remu.sv
rtl/positional_sequence_engine.sv
test/positional_sequence_engine_test.sv
